// File: hw/rtl/lpfp_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the length-prefixed field parser.
// No dependencies; every other file of the block imports this package.

package lpfp_pkg;

    // Largest size byte that still counts as a valid count of length bytes.
    localparam int MAX_LENGTH_BYTES = 8;
    // Position of a length byte inside the little-endian length word (0..7).
    localparam int LEN_POS_W        = 3;
    localparam int LEN_LEFT_W       = 4;

    localparam int BYTE_W           = 8;
    localparam int FIELD_NUM_W      = 16;
    localparam int VALUE_LEN_W      = 32;

    // Configuration register indexes.
    localparam int CFG_INDEX_W      = 1;
    localparam logic [CFG_INDEX_W-1:0] REG_EMPTY_MARKER     = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_MAX_VALUE_LENGTH = 1'b1;
    localparam logic [BYTE_W-1:0]      EMPTY_MARKER_RST     = 8'h00;
    localparam logic [VALUE_LEN_W-1:0] MAX_VALUE_LENGTH_RST = 32'hFFFF_FFFF;

    // Result queue between the parser and the output port (power of two).
    localparam int QUEUE_DEPTH      = 4;
    localparam int QUEUE_PTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef logic [BYTE_W-1:0]      byte_val_t;
    typedef logic [FIELD_NUM_W-1:0] field_num_t;
    typedef logic [VALUE_LEN_W-1:0] value_len_t;
    typedef logic [CFG_INDEX_W-1:0] cfg_index_t;

    typedef enum logic [1:0] {
        ERR_OK        = 2'd0,
        ERR_SIZE_BYTE = 2'd1,
        ERR_LENGTH    = 2'd2,
        ERR_TRUNCATED = 2'd3
    } err_code_t;

    typedef enum logic [3:0] {
        PH_SIZE = 4'b0001,
        PH_LEN  = 4'b0010,
        PH_VAL  = 4'b0100,
        PH_ERR  = 4'b1000
    } phase_t;

    typedef struct packed {
        byte_val_t  value_byte;
        field_num_t field_number;
        logic       field_empty;
        logic       field_end;
        err_code_t  error_code;
    } result_t;

endpackage

// File: hw/rtl/lpfp_if.sv
`timescale 1ns / 1ps
// Channel interfaces of the length-prefixed field parser: row bytes in,
// field results out, and the configuration write channel. Uses lpfp_pkg.

interface lpfp_row_if;
    import lpfp_pkg::*;

    logic      valid;
    logic      ready;
    byte_val_t row_byte;
    logic      row_last;

    modport source (output valid, output row_byte, output row_last, input ready);
    modport sink   (input valid, input row_byte, input row_last, output ready);
endinterface

interface lpfp_field_if;
    import lpfp_pkg::*;

    logic       valid;
    logic       ready;
    byte_val_t  value_byte;
    field_num_t field_number;
    logic       field_empty;
    logic       field_end;
    err_code_t  error_code;

    modport source (output valid, output value_byte, output field_number,
                    output field_empty, output field_end, output error_code,
                    input ready);
    modport sink   (input valid, input value_byte, input field_number,
                    input field_empty, input field_end, input error_code,
                    output ready);
endinterface

interface lpfp_cfg_if;
    import lpfp_pkg::*;

    logic       valid;
    logic       ready;
    cfg_index_t index;
    value_len_t data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// File: hw/rtl/lpfp_front.sv
`timescale 1ns / 1ps
// Parser front end: accepts row bytes, tracks the field phase and builds
// at most one result per byte. Holds the configuration registers.
// Depends on lpfp_pkg and lpfp_if.

module lpfp_front
(
    input  logic               clk,
    input  logic               rst_n,
    lpfp_row_if.sink           row,
    lpfp_cfg_if.sink           cfg,
    output logic               res_valid,
    output lpfp_pkg::result_t  res,
    input  logic               res_ready
);
    import lpfp_pkg::*;

    byte_val_t             empty_marker_reg;
    value_len_t            max_len_reg;

    phase_t                phase_reg,     phase_next;
    logic [LEN_LEFT_W-1:0] len_left_reg,  len_left_next;
    logic [LEN_POS_W-1:0]  len_pos_reg,   len_pos_next;
    value_len_t            len_acc_reg,   len_acc_next;
    logic                  len_high_reg,  len_high_next;
    value_len_t            val_left_reg,  val_left_next;
    field_num_t            field_cnt_reg, field_cnt_next;
    logic                  row_start_reg, row_start_next;

    logic       accept;
    logic       emit;
    result_t    res_c;
    field_num_t field_inc;
    value_len_t len_acc_merged;
    logic       len_high_merged;

    assign cfg.ready = 1'b1;
    assign row.ready = res_ready;
    assign accept    = row.valid && row.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            empty_marker_reg <= EMPTY_MARKER_RST;
            max_len_reg      <= MAX_VALUE_LENGTH_RST;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                REG_EMPTY_MARKER:     empty_marker_reg <= cfg.data[BYTE_W-1:0];
                REG_MAX_VALUE_LENGTH: max_len_reg      <= cfg.data;
                default:              ;
            endcase
        end
    end

    assign field_inc = (field_cnt_reg == '1) ? field_cnt_reg : field_cnt_reg + 1'b1;

    // Length bytes at positions four and above only matter for being non-zero,
    // since the maximum length fits in 32 bits.
    always_comb
    begin
        len_acc_merged  = len_acc_reg;
        len_high_merged = len_high_reg;
        if (len_pos_reg[LEN_POS_W-1])
        begin
            len_high_merged = len_high_reg || (row.row_byte != '0);
        end
        else
        begin
            len_acc_merged = len_acc_reg |
                (value_len_t'(row.row_byte) << {len_pos_reg[LEN_POS_W-2:0], 3'b000});
        end
    end

    always_comb
    begin
        phase_next     = phase_reg;
        len_left_next  = len_left_reg;
        len_pos_next   = len_pos_reg;
        len_acc_next   = len_acc_reg;
        len_high_next  = len_high_reg;
        val_left_next  = val_left_reg;
        field_cnt_next = field_cnt_reg;
        row_start_next = row_start_reg;

        emit               = 1'b0;
        res_c.value_byte   = '0;
        res_c.field_number = field_cnt_reg;
        res_c.field_empty  = 1'b0;
        res_c.field_end    = 1'b0;
        res_c.error_code   = ERR_OK;

        unique case (phase_reg)
            PH_SIZE:
            begin
                row_start_next = 1'b0;
                if (row.row_byte == empty_marker_reg)
                begin
                    // An empty marker opening the row is silent.
                    emit              = !row_start_reg;
                    res_c.field_empty = 1'b1;
                    res_c.field_end   = 1'b1;
                    field_cnt_next    = field_inc;
                end
                else if (row.row_byte > BYTE_W'(MAX_LENGTH_BYTES))
                begin
                    emit             = 1'b1;
                    res_c.field_end  = 1'b1;
                    res_c.error_code = ERR_SIZE_BYTE;
                    phase_next       = PH_ERR;
                end
                else if (row.row_byte == '0)
                begin
                    emit              = 1'b1;
                    res_c.field_empty = 1'b1;
                    res_c.field_end   = 1'b1;
                    field_cnt_next    = field_inc;
                end
                else
                begin
                    len_left_next = row.row_byte[LEN_LEFT_W-1:0];
                    len_pos_next  = '0;
                    len_acc_next  = '0;
                    len_high_next = 1'b0;
                    phase_next    = PH_LEN;
                end
            end
            PH_LEN:
            begin
                len_acc_next  = len_acc_merged;
                len_high_next = len_high_merged;
                len_pos_next  = len_pos_reg + 1'b1;
                len_left_next = len_left_reg - 1'b1;
                if (len_left_reg == LEN_LEFT_W'(1))
                begin
                    if (len_high_merged || (len_acc_merged > max_len_reg))
                    begin
                        emit             = 1'b1;
                        res_c.field_end  = 1'b1;
                        res_c.error_code = ERR_LENGTH;
                        phase_next       = PH_ERR;
                    end
                    else if (len_acc_merged == '0)
                    begin
                        emit              = 1'b1;
                        res_c.field_empty = 1'b1;
                        res_c.field_end   = 1'b1;
                        field_cnt_next    = field_inc;
                        phase_next        = PH_SIZE;
                    end
                    else
                    begin
                        val_left_next = len_acc_merged;
                        phase_next    = PH_VAL;
                    end
                end
            end
            PH_VAL:
            begin
                emit             = 1'b1;
                res_c.value_byte = row.row_byte;
                res_c.field_end  = (val_left_reg == VALUE_LEN_W'(1));
                val_left_next    = val_left_reg - 1'b1;
                if (val_left_reg == VALUE_LEN_W'(1))
                begin
                    field_cnt_next = field_inc;
                    phase_next     = PH_SIZE;
                end
            end
            PH_ERR:
            begin
                // Bytes are dropped until the end of the row.
            end
            default:
            begin
                phase_next = PH_SIZE;
            end
        endcase

        if (row.row_last)
        begin
            if ((phase_next == PH_LEN) || (phase_next == PH_VAL))
            begin
                if (!emit)
                begin
                    res_c.value_byte  = '0;
                    res_c.field_empty = 1'b0;
                end
                emit             = 1'b1;
                res_c.field_end  = 1'b1;
                res_c.error_code = ERR_TRUNCATED;
            end
            phase_next     = PH_SIZE;
            len_left_next  = '0;
            len_pos_next   = '0;
            len_acc_next   = '0;
            len_high_next  = 1'b0;
            val_left_next  = '0;
            field_cnt_next = '0;
            row_start_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_SIZE;
            len_left_reg  <= '0;
            len_pos_reg   <= '0;
            len_acc_reg   <= '0;
            len_high_reg  <= 1'b0;
            val_left_reg  <= '0;
            field_cnt_reg <= '0;
            row_start_reg <= 1'b1;
        end
        else if (accept)
        begin
            phase_reg     <= phase_next;
            len_left_reg  <= len_left_next;
            len_pos_reg   <= len_pos_next;
            len_acc_reg   <= len_acc_next;
            len_high_reg  <= len_high_next;
            val_left_reg  <= val_left_next;
            field_cnt_reg <= field_cnt_next;
            row_start_reg <= row_start_next;
        end
    end

    assign res_valid = accept && emit;
    assign res       = res_c;

    a_error_closes_field: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && (res.error_code != ERR_OK)) |-> (res.field_end && !res.field_empty))
        else $error("error result without field end");

    a_empty_is_blank: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res.field_empty) |-> (res.field_end && (res.value_byte == '0)))
        else $error("empty result carries data");

    a_row_end_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && row.row_last) |=>
            ((phase_reg == PH_SIZE) && row_start_reg && (field_cnt_reg == '0)))
        else $error("row state not cleared after last byte");

    a_value_phase_count: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_VAL) |-> (val_left_reg != '0))
        else $error("value phase with nothing left");

endmodule

// File: hw/rtl/lpfp_queue.sv
`timescale 1ns / 1ps
// Short result queue between the parser front end and the output port.
// Depends on lpfp_pkg.

module lpfp_queue
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push_valid,
    output logic               push_ready,
    input  lpfp_pkg::result_t  push_data,
    output logic               pop_valid,
    input  logic               pop_ready,
    output lpfp_pkg::result_t  pop_data
);
    import lpfp_pkg::*;

    result_t                mem_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_CNT_W-1:0] count_reg,  count_next;
    logic                   push;
    logic                   pop;

    assign push_ready = (count_reg != QUEUE_CNT_W'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;
    assign pop_data   = mem_reg[rd_ptr_reg];

    // Depth is a power of two, so the pointers wrap on their own.
    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= QUEUE_CNT_W'(QUEUE_DEPTH))
        else $error("queue count beyond depth");

    a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != QUEUE_CNT_W'(QUEUE_DEPTH)) |->
            (QUEUE_PTR_W'(wr_ptr_reg - rd_ptr_reg) == count_reg[QUEUE_PTR_W-1:0]))
        else $error("queue pointers disagree with count");

    a_no_lost_push: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("push not counted");

endmodule

// File: hw/rtl/length_prefixed_field_parser.sv
`timescale 1ns / 1ps
// Top level of the length-prefixed field parser: parser front end plus a
// result queue. Depends on lpfp_pkg, lpfp_if, lpfp_front and lpfp_queue.
//
//  Channel  Dir  Handshake     Payload
//  -------  ---  ------------  ------------------------------------------------
//  row      in   valid/ready   row_byte[7:0], row_last
//  field    out  valid/ready   value_byte[7:0], field_number[15:0], field_empty,
//                              field_end, error_code[1:0]
//  cfg      in   valid/ready   index[0:0], data[31:0] (ready is always high)
//
// One row byte is taken per cycle while the result queue has room; its result, if
// any, reaches the queue in the same cycle and can leave on the field channel in
// the next one. The front end stalls only when the four-entry result queue is full,
// so a stall on the field channel reaches the row channel only once the queue fills.
// Reset clears the parse state and the queue and loads the configuration
// registers with empty marker 0 and maximum value length 0xFFFFFFFF.

module length_prefixed_field_parser
(
    input  logic        clk,
    input  logic        rst_n,
    lpfp_row_if.sink    row,
    lpfp_field_if.source field,
    lpfp_cfg_if.sink    cfg
);
    import lpfp_pkg::*;

    logic    res_valid;
    logic    res_ready;
    result_t res;
    result_t out_data;

    // The front end classifies each byte by parse phase and builds the request
    // for the field channel; the configuration registers live in it too.
    lpfp_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .row       (row),
        .cfg       (cfg),
        .res_valid (res_valid),
        .res       (res),
        .res_ready (res_ready)
    );

    // The queue holds finished requests so that a stalled consumer does not
    // stop the parser at once.
    lpfp_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (res_valid),
        .push_ready (res_ready),
        .push_data  (res),
        .pop_valid  (field.valid),
        .pop_ready  (field.ready),
        .pop_data   (out_data)
    );

    assign field.value_byte   = out_data.value_byte;
    assign field.field_number = out_data.field_number;
    assign field.field_empty  = out_data.field_empty;
    assign field.field_end    = out_data.field_end;
    assign field.error_code   = out_data.error_code;

endmodule

// File: verif/lpfp_checker.sv
`timescale 1ns / 1ps
// Scoreboard of the length-prefixed field parser: follows the row, field and cfg channels,
// predicts every field result and compares it with what the block delivers.
// Depends on lpfp_pkg and the channel interfaces in lpfp_if.

module lpfp_checker
(
    input  logic  clk,
    input  logic  rst_n,
    lpfp_row_if   row,
    lpfp_field_if field,
    lpfp_cfg_if   cfg,
    output int    mismatches,
    output int    outstanding
);
    import lpfp_pkg::*;

    // Shadow copies of the configuration registers.
    byte_val_t   marker_copy;
    value_len_t  max_len_copy;

    // Shadow parse state.
    phase_t      phase;
    logic [3:0]  len_left;
    logic [2:0]  len_pos;
    logic [63:0] len_acc;
    logic [63:0] val_left;
    field_num_t  field_ctr;
    logic        row_start;

    result_t     expected_fields[$];
    result_t     oldest;

    function automatic result_t make_result(input byte_val_t vb, input logic empty,
                                            input logic last_of_field, input err_code_t err);
        result_t r;
        r.value_byte   = vb;
        r.field_number = field_ctr;
        r.field_empty  = empty;
        r.field_end    = last_of_field;
        r.error_code   = err;
        return r;
    endfunction

    task automatic advance_field();
        if (field_ctr != 16'hFFFF)
            field_ctr++;
        phase = PH_SIZE;
    endtask

    task automatic clear_row();
        phase     = PH_SIZE;
        len_left  = '0;
        len_pos   = '0;
        len_acc   = '0;
        val_left  = '0;
        field_ctr = '0;
        row_start = 1'b1;
    endtask

    // Works out the result, if any, that one row byte causes and queues it.
    task automatic predict_fields(input byte_val_t b, input logic last);
        result_t res;
        logic    have;
        logic    first;
        have = 1'b0;
        res  = '0;
        case (phase)
            PH_SIZE:
            begin
                first     = row_start;
                row_start = 1'b0;
                if (b == marker_copy)
                begin
                    if (!first)
                    begin
                        res  = make_result(8'h00, 1'b1, 1'b1, ERR_OK);
                        have = 1'b1;
                    end
                    advance_field();
                end
                else if (b > MAX_LENGTH_BYTES)
                begin
                    res   = make_result(8'h00, 1'b0, 1'b1, ERR_SIZE_BYTE);
                    have  = 1'b1;
                    phase = PH_ERR;
                end
                else if (b == 8'h00)
                begin
                    res  = make_result(8'h00, 1'b1, 1'b1, ERR_OK);
                    have = 1'b1;
                    advance_field();
                end
                else
                begin
                    len_left = b[3:0];
                    len_pos  = '0;
                    len_acc  = '0;
                    phase    = PH_LEN;
                end
            end
            PH_LEN:
            begin
                len_acc  = len_acc | (64'(b) << (8 * len_pos));
                len_pos  = len_pos + 3'd1;
                len_left = len_left - 4'd1;
                if (len_left == 4'd0)
                begin
                    if (len_acc > {32'd0, max_len_copy})
                    begin
                        res   = make_result(8'h00, 1'b0, 1'b1, ERR_LENGTH);
                        have  = 1'b1;
                        phase = PH_ERR;
                    end
                    else if (len_acc == 64'd0)
                    begin
                        res  = make_result(8'h00, 1'b1, 1'b1, ERR_OK);
                        have = 1'b1;
                        advance_field();
                    end
                    else
                    begin
                        val_left = len_acc;
                        phase    = PH_VAL;
                    end
                end
            end
            PH_VAL:
            begin
                res      = make_result(b, 1'b0, val_left == 64'd1, ERR_OK);
                have     = 1'b1;
                val_left = val_left - 64'd1;
                if (val_left == 64'd0)
                    advance_field();
            end
            default:
            begin
            end
        endcase

        if (last)
        begin
            // A row that stops inside a field is reported as truncated.
            if (phase == PH_LEN || phase == PH_VAL)
            begin
                if (have)
                begin
                    res.field_end  = 1'b1;
                    res.error_code = ERR_TRUNCATED;
                end
                else
                begin
                    res  = make_result(8'h00, 1'b0, 1'b1, ERR_TRUNCATED);
                    have = 1'b1;
                end
            end
            clear_row();
        end

        if (have)
            expected_fields = {expected_fields, res};
    endtask

    task automatic compare_field(input string name, input logic [15:0] want,
                                 input logic [15:0] got);
        if (got !== want)
        begin
            $error("%s mismatch: expected %0h, actual %0h", name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            marker_copy  = EMPTY_MARKER_RST;
            max_len_copy = MAX_VALUE_LENGTH_RST;
            clear_row();
            expected_fields.delete();
            mismatches  = 0;
            outstanding <= 0;
        end
        else
        begin
            // The block answers a byte in the cycle after it is taken at the earliest, so results
            // are checked before the byte taken at the same edge is predicted.
            if (field.valid && field.ready)
            begin
                if (expected_fields.size() == 0)
                begin
                    $error("unexpected field result: value_byte %0h field_number %0d",
                           field.value_byte, field.field_number);
                    mismatches++;
                end
                else
                begin
                    oldest = expected_fields.pop_front();
                    compare_field("value_byte", 16'(oldest.value_byte), 16'(field.value_byte));
                    compare_field("field_number", oldest.field_number, field.field_number);
                    compare_field("field_empty", 16'(oldest.field_empty),
                                  16'(field.field_empty));
                    compare_field("field_end", 16'(oldest.field_end), 16'(field.field_end));
                    compare_field("error_code", 16'(oldest.error_code),
                                  16'(field.error_code));
                end
            end
            if (cfg.valid && cfg.ready)
            begin
                if (cfg.index == REG_EMPTY_MARKER)
                    marker_copy = cfg.data[BYTE_W-1:0];
                else if (cfg.index == REG_MAX_VALUE_LENGTH)
                    max_len_copy = cfg.data;
            end
            if (row.valid && row.ready)
                predict_fields(row.row_byte, row.row_last);
            outstanding <= expected_fields.size();
        end
    end

endmodule

// File: verif/testbench.sv
`timescale 1ns / 1ps
// Top of the length-prefixed field parser testbench: clock, reset, row and config
// stimulus, field receiver, watchdog and verdict. Depends on lpfp_pkg, lpfp_if,
// the parser RTL and lpfp_checker.

module testbench;
    import lpfp_pkg::*;

    // Longest run of cycles in which no request of any channel is accepted before the
    // run is declared hung. The deliberate receiver hold-off is far shorter than this.
    localparam int QUIET_LIMIT  = 2000;
    localparam int HOLD_CYCLES  = 400;
    // Input requests per random segment; six segments follow the directed rows.
    localparam int SEGMENT_REQS = 245;
    localparam int SEGMENTS     = 6;

    logic clk;
    logic rst_n;

    lpfp_row_if   row_bus();
    lpfp_field_if field_bus();
    lpfp_cfg_if   cfg_bus();

    int mismatches;
    int outstanding;

    // Idle percentages for the sender and the receiver, set per phase by the stimulus.
    int send_idle_pct;
    int recv_idle_pct;
    // Raised once by the stimulus to ask the receiver for its long hold-off.
    logic hold_request;

    // Current register values, kept only to shape the stimulus.
    byte_val_t  marker_now;
    value_len_t max_now;

    byte_val_t row_buf[$];
    int        reqs_sent;

    length_prefixed_field_parser dut
    (
        .clk   (clk),
        .rst_n (rst_n),
        .row   (row_bus),
        .field (field_bus),
        .cfg   (cfg_bus)
    );

    lpfp_checker scoreboard
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .row         (row_bus),
        .field       (field_bus),
        .cfg         (cfg_bus),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Adds one byte at the end of the row being built.
    task automatic append_byte(input byte_val_t b);
        row_buf = {row_buf, b};
    endtask

    // Offers one row byte, after a random number of idle cycles, and holds it until the
    // block takes the request. Valid stays high when the next byte follows without a gap.
    task automatic send_byte(input byte_val_t b, input logic last);
        while ($urandom_range(99) < send_idle_pct)
        begin
            row_bus.valid <= 1'b0;
            @(posedge clk);
        end
        row_bus.valid    <= 1'b1;
        row_bus.row_byte <= b;
        row_bus.row_last <= last;
        @(posedge clk);
        while (!row_bus.ready)
            @(posedge clk);
        reqs_sent++;
    endtask

    task automatic send_row();
        for (int i = 0; i < row_buf.size(); i++)
            send_byte(row_buf[i], i == row_buf.size() - 1);
    endtask

    // Lets the block run dry: every predicted result has to arrive, and the bench then
    // waits on for a byte that caused no result and may still be in flight.
    task automatic drain();
        row_bus.valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Writes both registers back to back; valid is only lowered after the second write.
    task automatic apply_settings(input byte_val_t marker, input value_len_t max_len);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= REG_EMPTY_MARKER;
        cfg_bus.data  <= value_len_t'(marker);
        @(posedge clk);
        while (!cfg_bus.ready)
            @(posedge clk);
        cfg_bus.index <= REG_MAX_VALUE_LENGTH;
        cfg_bus.data  <= max_len;
        @(posedge clk);
        while (!cfg_bus.ready)
            @(posedge clk);
        cfg_bus.valid <= 1'b0;
        marker_now = marker;
        max_now    = max_len;
    endtask

    // Builds one row in row_buf. Most rows are well formed: an optional skipped marker,
    // then a handful of fields that are empty, zero length or carry a short value. Some
    // fields are broken on purpose (an oversized size byte, or a length word that is far
    // too large) and are followed by junk that the block must drop. A share of rows is
    // cut short to provoke truncation, and a tenth are plain noise.
    task automatic compose_row();
        int          field_count;
        int          pick;
        int          size_n;
        int          keep;
        logic [63:0] length_word;
        row_buf.delete();
        if ($urandom_range(9) == 0)
        begin
            repeat ($urandom_range(10, 1)) append_byte(byte_val_t'($urandom));
        end
        else
        begin
            if ($urandom_range(3) == 0)
                append_byte(marker_now);
            field_count = $urandom_range(5);
            for (int f = 0; f < field_count; f++)
            begin
                pick = $urandom_range(99);
                if (pick < 10)
                    append_byte(marker_now);
                else if (pick < 16)
                    append_byte(8'h00);
                else if (pick < 26)
                begin
                    if (pick < 21)
                        append_byte(byte_val_t'($urandom_range(255, MAX_LENGTH_BYTES + 1)));
                    else
                    begin
                        append_byte(byte_val_t'(MAX_LENGTH_BYTES));
                        repeat (MAX_LENGTH_BYTES) append_byte(byte_val_t'($urandom));
                    end
                    repeat ($urandom_range(3)) append_byte(byte_val_t'($urandom));
                    break;
                end
                else
                begin
                    size_n = $urandom_range(MAX_LENGTH_BYTES, 1);
                    // With a small maximum, lengths right at and just above it are
                    // tried often; otherwise values stay short to keep the run brisk.
                    if (max_now <= 40 && $urandom_range(3) == 0)
                        length_word = 64'(max_now) + 64'($urandom_range(1));
                    else
                        length_word = 64'($urandom_range(12));
                    append_byte(byte_val_t'(size_n));
                    for (int i = 0; i < size_n; i++)
                        append_byte(byte_val_t'(length_word >> (8 * i)));
                    repeat (int'(length_word)) append_byte(byte_val_t'($urandom));
                end
            end
            if (row_buf.size() > 1 && $urandom_range(6) == 0)
            begin
                keep = $urandom_range(row_buf.size() - 1, 1);
                while (row_buf.size() > keep)
                    void'(row_buf.pop_back());
            end
        end
        if (row_buf.size() == 0)
            append_byte(byte_val_t'($urandom));
    endtask

    // Field receiver. Apart from the single long hold-off it drops ready at random in
    // the share of cycles that the current phase asks for.
    initial
    begin : field_receiver
        int hold_left;
        bit hold_used;
        hold_left = 0;
        hold_used = 1'b0;
        field_bus.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_request && !hold_used)
            begin
                hold_left = HOLD_CYCLES;
                hold_used = 1'b1;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                field_bus.ready <= 1'b0;
            end
            else
                field_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Watchdog: ends the run if no request is accepted on any channel for too long.
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((row_bus.valid && row_bus.ready) || (field_bus.valid && field_bus.ready) ||
                (cfg_bus.valid && cfg_bus.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("Simulation FAILED");
        $finish;
    end

    initial
    begin : stimulus
        int target;
        send_idle_pct = 31;
        recv_idle_pct = 55;
        hold_request  = 1'b0;
        marker_now    = EMPTY_MARKER_RST;
        max_now       = MAX_VALUE_LENGTH_RST;
        reqs_sent     = 0;

        rst_n            <= 1'b0;
        row_bus.valid    <= 1'b0;
        row_bus.row_byte <= '0;
        row_bus.row_last <= 1'b0;
        cfg_bus.valid    <= 1'b0;
        cfg_bus.index    <= REG_EMPTY_MARKER;
        cfg_bus.data     <= '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed rows with the reset settings (empty marker 0, no length limit).
        // A marker that opens the row is skipped, then a two-byte value and an empty field
        // closing the row.
        row_buf = {8'h00, 8'h01, 8'h02, 8'hAA, 8'h55, 8'h00};
        send_row();
        // Field 0 with a zero length spelt out in a length byte, then the widest length
        // word carrying a one-byte value that happens to close the row.
        row_buf = {8'h01, 8'h00, 8'h08, 8'h01, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
                   8'h00, 8'hFF};
        send_row();
        // The row ends inside a value: the value byte itself carries the truncation.
        row_buf = {8'h01, 8'h05, 8'h7E};
        send_row();
        // A length of 2^32 is just above the largest limit; the length error on the
        // final byte outranks the truncation.
        row_buf = {8'h05, 8'h00, 8'h00, 8'h00, 8'h00, 8'h01};
        send_row();

        for (int seg = 0; seg < SEGMENTS; seg++)
        begin
            // Two segments per idling pattern: receiver shy first, then sender shy,
            // then both flat out.
            if (seg < 2)
            begin
                send_idle_pct = 31;
                recv_idle_pct = 55;
            end
            else if (seg < 4)
            begin
                send_idle_pct = 55;
                recv_idle_pct = 31;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end

            drain();
            case (seg)
                0:       apply_settings(8'hFF, 32'hFFFF_FFFF);
                1:       apply_settings(8'h00, 32'h0000_0000);
                2:       apply_settings(byte_val_t'($urandom_range(MAX_LENGTH_BYTES, 1)),
                                        value_len_t'($urandom_range(20, 1)));
                3:       apply_settings(byte_val_t'($urandom_range(254, MAX_LENGTH_BYTES + 1)),
                                        32'd16);
                4:       apply_settings(byte_val_t'($urandom_range(255)),
                                        value_len_t'($urandom_range(40)));
                default: apply_settings(8'h00, 32'hFFFF_FFFF);
            endcase

            // The receiver stalls for a long stretch while bytes keep coming, so the
            // result queue fills and the row channel has to back off.
            if (seg == 0)
                hold_request = 1'b1;

            target = reqs_sent + SEGMENT_REQS;
            while (reqs_sent < target)
            begin
                compose_row();
                send_row();
            end
        end

        drain();
        repeat (10) @(posedge clk);
        if (mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
